// ----- hw/rtl/ordered_list_engine_defines.svh -----
// Assertion macros for the ordered list engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Expects ports named clock and reset in the including module.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define OLE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered_list_engine check failed");
// next-cycle implication, checked outside reset
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered_list_engine check failed");
`else
`define OLE_ASSERT_NOW(lbl, ante, cons)
`define OLE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
// No dependencies; used by ordered_list_engine.
package ole_pkg;

   localparam int unsigned REQ_DATA_BITS = 32;
   localparam int unsigned REQ_USER_BITS = 3;
   localparam int unsigned RSP_DATA_BITS = 40;
   localparam int unsigned RSP_USER_BITS = 2;
   localparam int unsigned VALUE_FIELD_BITS = 32;
   localparam int unsigned COUNT_FIELD_BITS = 5;

   typedef enum logic [2:0] {
      OP_APPEND       = 3'd0,
      OP_PUSH_HEAD    = 3'd1,
      OP_REMOVE_VALUE = 3'd2,
      OP_POP_HEAD     = 3'd3,
      OP_POP_TAIL     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TAKE,
      S_WALK,
      S_RESP
   } state_type;

endpackage

// ----- hw/rtl/ole_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instanced by ordered_list_engine for the entry store.
module ole_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ordered_list_engine.sv -----
// Ordered list engine top level: request decode, list sequencer, result register.
// Depends on ole_pkg, ole_ram and ordered_list_engine_defines.svh.
`include "ordered_list_engine_defines.svh"

// A bounded ordered list of values kept as a ring of CAPACITY slots in one
// synchronous RAM (one write and one registered read port). Each request beat carries
// an opcode in req_tuser and a value in req_tdata; exactly one response beat comes
// back per request with a status in rsp_tuser, the removed value and the new count
// in rsp_tdata. One request is worked on at a time. Append, insert at head, unknown
// opcodes and any removal from an empty list go from decode straight to the
// response; remove head and remove tail first take one RAM read; remove by value
// walks the list through the single read port, one entry per cycle, takes in the
// last read data and closes out the pass, and the entries behind the match are
// moved up one slot each in the same pass through the write port.
// A full list rejects inserts
// with status full, removals from an empty list report empty, and a value that is
// absent reports not found; in each case the list is left as it was and the removed
// value is zero. The next request is taken in the cycle after the response is parked
// in the output register, even if the downstream side has not yet taken it; a response
// still waiting in the output register holds the sequencer until it is taken. No
// clearing pass is needed after reset: only slots that hold live entries are ever read.
module ordered_list_engine #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value
   input  logic [ole_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [2:0] opcode
   input  logic [ole_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] removed_value, [36:32] count, [39:37] zero
   output logic [ole_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // [1:0] status
   output logic [ole_pkg::RSP_USER_BITS-1:0]   rsp_tuser
);

   localparam int unsigned AW = $clog2(CAPACITY);     // slot index
   localparam int unsigned CW = $clog2(CAPACITY + 1); // entry count

   // ring slot of list position pos, both below CAPACITY
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW+1)'(CAPACITY)) begin
         s = s - (AW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   // sequencer and list state
   ole_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      first_ff, first_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   // search walk
   logic [CW-1:0]      pos_ff, pos_in;       // next position to read
   logic               rd_pend_ff, rd_pend_in; // read data arrives this cycle
   logic [CW-1:0]      rd_pos_ff, rd_pos_in;  // position of that read data
   logic               found_ff, found_in;

   // result held until the output register frees up
   logic [1:0]            res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_removed_ff, res_removed_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [ole_pkg::VALUE_FIELD_BITS-1:0] rsp_removed_ff;
   logic [ole_pkg::COUNT_FIELD_BITS-1:0] rsp_count_ff;

   // RAM port
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

   logic req_fire, out_free, rsp_load;
   logic list_full, list_empty;
   logic walk_issue, walk_done;
   logic [CW-1:0] count_m1, rd_pos_m1;
   logic [AW-1:0] first_inc, first_dec;

   // field width adaptation (value field is fixed at 32 bits on the ports)
   logic [VALUE_BITS+ole_pkg::VALUE_FIELD_BITS-1:0] req_val_wide;
   logic [VALUE_BITS+ole_pkg::VALUE_FIELD_BITS-1:0] res_removed_wide;
   logic [CW+ole_pkg::COUNT_FIELD_BITS-1:0]         count_wide;

   assign req_val_wide     = {{VALUE_BITS{1'b0}}, req_tdata[ole_pkg::VALUE_FIELD_BITS-1:0]};
   assign res_removed_wide = {{ole_pkg::VALUE_FIELD_BITS{1'b0}}, res_removed_ff};
   assign count_wide       = {{ole_pkg::COUNT_FIELD_BITS{1'b0}}, count_ff};

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ole_pkg::S_RESP) && out_free;
   assign list_full  = (count_ff == CW'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign count_m1   = count_ff - CW'(1);
   assign rd_pos_m1  = rd_pos_ff - CW'(1);
   assign first_inc  = (first_ff == AW'(CAPACITY - 1)) ? '0 : first_ff + AW'(1);
   assign first_dec  = (first_ff == '0) ? AW'(CAPACITY - 1) : first_ff - AW'(1);

   // walk: one read per cycle until every live position has been issued
   assign walk_issue = (pos_ff < count_ff);
   assign walk_done  = !rd_pend_ff && !walk_issue;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ole_pkg::S_IDLE: begin
            if (req_fire) state_in = ole_pkg::S_EXEC;
         end
         ole_pkg::S_EXEC: begin
            unique case (op_ff)
               ole_pkg::OP_REMOVE_VALUE: begin
                  state_in = list_empty ? ole_pkg::S_RESP : ole_pkg::S_WALK;
               end
               ole_pkg::OP_POP_HEAD, ole_pkg::OP_POP_TAIL: begin
                  state_in = list_empty ? ole_pkg::S_RESP : ole_pkg::S_TAKE;
               end
               default: state_in = ole_pkg::S_RESP;
            endcase
         end
         ole_pkg::S_TAKE: state_in = ole_pkg::S_RESP;
         ole_pkg::S_WALK: begin
            if (walk_done) state_in = ole_pkg::S_RESP;
         end
         ole_pkg::S_RESP: begin
            if (out_free) state_in = ole_pkg::S_IDLE;
         end
         default: state_in = ole_pkg::S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      req_tready     = (state_ff == ole_pkg::S_IDLE);
      op_in          = op_ff;
      val_in         = val_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      rd_pend_in     = 1'b0;
      rd_pos_in      = rd_pos_ff;
      found_in       = found_ff;
      res_status_in  = res_status_ff;
      res_removed_in = res_removed_ff;
      mem_we         = 1'b0;
      mem_waddr      = first_ff;
      mem_wdata      = val_ff;
      mem_re         = 1'b0;
      mem_raddr      = first_ff;

      unique case (state_ff)
         ole_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in  = req_tuser;
               val_in = req_val_wide[VALUE_BITS-1:0];
            end
         end
         ole_pkg::S_EXEC: begin
            res_status_in  = ole_pkg::ST_OK;
            res_removed_in = '0;
            pos_in         = '0;
            found_in       = 1'b0;
            unique case (op_ff)
               ole_pkg::OP_APPEND: begin
                  if (list_full) begin
                     res_status_in = ole_pkg::ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = wrap_add(first_ff, count_ff[AW-1:0]);
                     count_in  = count_ff + CW'(1);
                  end
               end
               ole_pkg::OP_PUSH_HEAD: begin
                  if (list_full) begin
                     res_status_in = ole_pkg::ST_FULL;
                  end else begin
                     first_in  = first_dec;
                     mem_we    = 1'b1;
                     mem_waddr = first_dec;
                     count_in  = count_ff + CW'(1);
                  end
               end
               ole_pkg::OP_REMOVE_VALUE: begin
                  if (list_empty) res_status_in = ole_pkg::ST_EMPTY;
               end
               ole_pkg::OP_POP_HEAD: begin
                  if (list_empty) begin
                     res_status_in = ole_pkg::ST_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = first_ff;
                  end
               end
               ole_pkg::OP_POP_TAIL: begin
                  if (list_empty) begin
                     res_status_in = ole_pkg::ST_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = wrap_add(first_ff, count_m1[AW-1:0]);
                  end
               end
               default: ; // unknown opcode: no change, status ok
            endcase
         end
         ole_pkg::S_TAKE: begin
            res_removed_in = mem_rdata;
            count_in       = count_m1;
            if (op_ff == ole_pkg::OP_POP_HEAD) first_in = first_inc;
         end
         ole_pkg::S_WALK: begin
            if (walk_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = wrap_add(first_ff, pos_ff[AW-1:0]);
               pos_in     = pos_ff + CW'(1);
               rd_pend_in = 1'b1;
               rd_pos_in  = pos_ff;
            end
            if (rd_pend_ff) begin
               if (found_ff) begin
                  // close the gap: entry moves one place toward the head
                  mem_we    = 1'b1;
                  mem_waddr = wrap_add(first_ff, rd_pos_m1[AW-1:0]);
                  mem_wdata = mem_rdata;
               end else if (mem_rdata == val_ff) begin
                  found_in       = 1'b1;
                  res_removed_in = mem_rdata;
               end
            end
            if (walk_done) begin
               if (found_ff) begin
                  count_in = count_m1;
               end else begin
                  res_status_in = ole_pkg::ST_MISSING;
               end
            end
         end
         ole_pkg::S_RESP: ;
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ole_pkg::S_IDLE;
         first_ff     <= '0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      rd_pos_ff      <= rd_pos_in;
      found_ff       <= found_in;
      res_status_ff  <= res_status_in;
      res_removed_ff <= res_removed_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_removed_ff <= res_removed_wide[ole_pkg::VALUE_FIELD_BITS-1:0];
         rsp_count_ff   <= count_wide[ole_pkg::COUNT_FIELD_BITS-1:0];
      end
   end

   ole_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_removed_ff};

   // a read and a write never hit the same slot in one cycle
   `OLE_ASSERT_NOW(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr)
   // during the walk, entries move only once the match has been seen
   `OLE_ASSERT_NOW(a_shift_after_match, mem_we && (state_ff == ole_pkg::S_WALK), found_ff)
   // the list never holds more than its capacity
   `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY))
   // an accepted request is decoded on the next cycle
   `OLE_ASSERT_NEXT(a_accept_exec, req_fire, state_ff == ole_pkg::S_EXEC)

endmodule
